[rtl/tdac_pkg.sv]
`timescale 1ns / 1ps
// tdac_pkg: types, constants and tables shared by the temperature to ascii core
// no dependencies

package tdac_pkg;

    localparam int RAW_W        = 12;
    localparam int CHAR_W       = 7;
    localparam int COL_W        = 3;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    localparam int SUFFIX_LENGTH = 6;
    localparam int SUFFIX_MAX    = 7;
    localparam int SUFFIX_USED   = (SUFFIX_LENGTH > SUFFIX_MAX) ? SUFFIX_MAX : SUFFIX_LENGTH;
    localparam int HEAD_CHARS    = 7;
    localparam int TOTAL_CHARS   = HEAD_CHARS + SUFFIX_USED;
    localparam int IDX_W         = $clog2(HEAD_CHARS + SUFFIX_MAX);

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
    localparam logic [2:0]        DIGIT_HI   = 3'b011;

    localparam logic [CHAR_W-1:0] SUFFIX_WORD [SUFFIX_MAX] = '{
        7'h43, 7'h65, 7'h6C, 7'h73, 7'h69, 7'h75, 7'h73
    };

    // (25*f+2)>>2 for the low nibble f, as two bcd digits
    localparam logic [7:0] FRAC_BCD [16] = '{
        8'h00, 8'h06, 8'h13, 8'h19, 8'h25, 8'h31, 8'h38, 8'h44,
        8'h50, 8'h56, 8'h63, 8'h69, 8'h75, 8'h81, 8'h88, 8'h94
    };

    typedef struct packed {
        logic       neg;
        logic [3:0] d4;
        logic [3:0] d3;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } digits_t;

endpackage

[rtl/tdac_digits.sv]
`timescale 1ns / 1ps
// tdac_digits: splits a signed 1/16 degree reading into sign and five decimal digits
// depends on tdac_pkg

module tdac_digits
    import tdac_pkg::*;
(
    input  logic [RAW_W-1:0] raw,
    output digits_t          digits
);

    logic             neg;
    logic [RAW_W-1:0] mag;
    logic [7:0]       whole;
    logic             hundred;
    logic [6:0]       rem;
    logic [14:0]      tens_prod;
    logic [3:0]       tens;
    logic [7:0]       tens_x10;
    logic [7:0]       units;
    logic [7:0]       frac;

    // the whole degrees are the magnitude above the nibble, the nibble gives the fraction
    always_comb begin
        neg       = raw[RAW_W-1];
        mag       = neg ? (~raw + 1'b1) : raw;
        whole     = mag[RAW_W-1:4];
        hundred   = (whole >= 8'd100);
        rem       = 7'(whole - (hundred ? 8'd100 : 8'd0));
        // rem below 100, so rem*205 >> 11 is rem/10
        tens_prod = 15'(rem) * 15'd205;
        tens      = tens_prod[14:11];
        tens_x10  = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
        units     = {1'b0, rem} - tens_x10;
        frac      = FRAC_BCD[mag[3:0]];

        digits.neg = neg;
        digits.d4  = {3'b000, hundred};
        digits.d3  = tens;
        digits.d2  = units[3:0];
        digits.d1  = frac[7:4];
        digits.d0  = frac[3:0];
    end

endmodule

[rtl/temperature_to_decimal_ascii_core.sv]
`timescale 1ns / 1ps
// temperature_to_decimal_ascii_core: turns a temperature reading into a run of ascii characters
// depends on tdac_pkg and tdac_digits

// Each accepted reading (12-bit two's complement, 1/16 degree per LSB, in s_axis_tdata[11:0])
// gives a run of 13 characters on the master side, one per cycle unless m_axis_tready is low:
// sign, three integer digits, point, two fraction digits rounded to hundredths, then "Celsiu".
// The first seven characters carry the display column and have tuser set; tlast marks the
// final character. A reading is held in a one-deep input register while the previous run is
// still going out, so a new reading can be taken before the previous run is finished; the
// character sequencer drives the single output register. On an idle block a reading passes
// through the input register and the current register before it reaches the output register.

module temperature_to_decimal_ascii_core
    import tdac_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [11:0] raw_reading, rest zero

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [6:0] char_code, [9:7] lcd_column, rest zero
    output logic                 m_axis_tuser,   // [0] lcd_write
    output logic                 m_axis_tlast
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOTAL_CHARS - 1);
    localparam logic [IDX_W-1:0] HEAD_END = IDX_W'(HEAD_CHARS);

    digits_t          in_digits;
    digits_t          pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    digits_t          cur_reg, cur_next;
    logic             active_reg, active_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic              out_wr_reg, out_wr_next;
    logic              out_last_reg, out_last_next;

    logic              s_accept;
    logic              out_free;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic              wr;
    logic [2:0]        sfx_sel;

    tdac_digits u_digits (
        .raw    (s_axis_tdata[RAW_W-1:0]),
        .digits (in_digits)
    );

    assign s_axis_tready = !pend_valid_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // character for the current position of the run
    always_comb begin
        sfx_sel = 3'(idx_reg - HEAD_END);
        ch      = SUFFIX_WORD[sfx_sel];
        col     = '0;
        wr      = 1'b0;
        if (idx_reg < HEAD_END) begin
            wr  = 1'b1;
            col = (idx_reg == '0) ? '0 : COL_W'(idx_reg + 1'b1);
            case (idx_reg)
                4'd0:    ch = cur_reg.neg ? CHAR_MINUS : CHAR_PLUS;
                4'd1:    ch = {DIGIT_HI, cur_reg.d4};
                4'd2:    ch = {DIGIT_HI, cur_reg.d3};
                4'd3:    ch = {DIGIT_HI, cur_reg.d2};
                4'd4:    ch = CHAR_POINT;
                4'd5:    ch = {DIGIT_HI, cur_reg.d1};
                default: ch = {DIGIT_HI, cur_reg.d0};
            endcase
        end
    end

    always_comb begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cur_next        = cur_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_char_next   = out_char_reg;
        out_col_next    = out_col_reg;
        out_wr_next     = out_wr_reg;
        out_last_next   = out_last_reg;

        if (s_accept) begin
            pend_next       = in_digits;
            pend_valid_next = 1'b1;
        end

        if (active_reg && out_free) begin
            out_valid_next = 1'b1;
            out_char_next  = ch;
            out_col_next   = col;
            out_wr_next    = wr;
            out_last_next  = (idx_reg == LAST_IDX);
            if (idx_reg == LAST_IDX) begin
                idx_next = '0;
                // chain the waiting reading straight on
                if (pend_valid_reg) begin
                    cur_next        = pend_reg;
                    pend_valid_next = 1'b0;
                end else begin
                    active_next = 1'b0;
                end
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end else if (!active_reg && pend_valid_reg) begin
            cur_next        = pend_reg;
            pend_valid_next = 1'b0;
            active_next     = 1'b1;
            idx_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_reg     <= pend_next;
        cur_reg      <= cur_next;
        out_char_reg <= out_char_next;
        out_col_reg  <= out_col_next;
        out_wr_reg   <= out_wr_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - CHAR_W - COL_W)'(0), out_col_reg, out_char_reg};
    assign m_axis_tuser  = out_wr_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
